>>> rtl/raace_pkg.sv
// Shared types, constants and codes of the AVI audio chunk extractor.
`default_nettype none

package raace_pkg;

  // Byte positions saturate at the top of a 34-bit counter.
  localparam int POS_W = 34;
  // Container ends can reach one past the largest position plus a chunk size.
  localparam int END_W = POS_W + 1;
  // Remaining payload bytes of a chunk, or header bytes while a header is read.
  localparam int CNT_W = 32;
  localparam int MAX_NESTING_DEF = 8;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_MOVI = 32'h6D6F_7669;
  localparam logic [31:0] TAG_REC  = 32'h7265_6320;
  localparam logic [31:0] TAG_AVI  = 32'h4156_4920;
  localparam logic [7:0]  CHAR_W   = 8'h77;
  localparam logic [7:0]  CHAR_B   = 8'h62;

  localparam logic [2:0] OUT_OK         = 3'd0;
  localparam logic [2:0] OUT_BAD_HEADER = 3'd1;
  localparam logic [2:0] OUT_OVERRUN    = 3'd2;
  localparam logic [2:0] OUT_TOO_DEEP   = 3'd3;
  localparam logic [2:0] OUT_NO_AUDIO   = 3'd4;

  typedef enum logic [2:0] {
    PH_FILEHDR,
    PH_CHDR,
    PH_LISTTYPE,
    PH_DATA,
    PH_AUDIO,
    PH_PAD,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } src_item_t;

  typedef struct packed {
    logic [7:0] audio_byte;
    logic       audio_valid;
    logic       finished;
    logic [2:0] outcome;
  } res_item_t;

  // One open container.
  typedef struct packed {
    logic [END_W-1:0] end_pos;
    logic             movie;
    logic             pad;
  } entry_t;

  // What one cell reports about its container for the current byte.
  typedef struct packed {
    logic             ge;
    logic             over;
    logic             top;
    logic             newtop;
    logic             lowest;
    logic             pad;
    logic             movie;
    logic [END_W-1:0] diff;
  } cell_stat_t;

  // What the stack reports to the parser for the current byte.
  typedef struct packed {
    logic             top_ge;
    logic             top_movie;
    logic [END_W-1:0] top_diff;
    logic             pop_pad;
    logic             nt_live;
    logic [END_W-1:0] nt_diff;
    logic             over;
  } stack_view_t;

endpackage

`default_nettype wire

>>> rtl/raace_cell.sv
// One container cell of the nesting stack: holds an end offset and its flags.
`default_nettype none

module raace_cell (
  input  logic                             clk,
  input  logic                             wr,
  input  raace_pkg::entry_t                wdata,
  input  logic [raace_pkg::END_W-1:0]      np,
  input  logic [raace_pkg::POS_W-1:0]      len,
  input  logic                             live,
  input  logic                             top,
  input  logic                             below_ge,
  input  logic                             above_ge,
  output raace_pkg::cell_stat_t            stat
);

  raace_pkg::entry_t entry;
  logic              ge;

  always_ff @(posedge clk) begin
    if (wr) begin
      entry <= wdata;
    end
  end

  assign ge = live && (np >= entry.end_pos);

  // Ends grow outward, so the closing cells form a run at the top. The lowest
  // closing cell and the cell just under the run are found from the neighbors.
  always_comb begin
    stat.ge     = ge;
    stat.over   = live && (entry.end_pos > {1'b0, len});
    stat.top    = top;
    stat.newtop = live && !ge && (top || above_ge);
    stat.lowest = ge && !below_ge;
    stat.pad    = entry.pad;
    stat.movie  = entry.movie;
    stat.diff   = entry.end_pos - np;
  end

endmodule

`default_nettype wire

>>> rtl/raace_stack.sv
// Row of container cells with the selection of the top and of the new top.
`default_nettype none

module raace_stack #(
  parameter int MAX_NESTING = raace_pkg::MAX_NESTING_DEF,
  localparam int LVL_W = $clog2(MAX_NESTING + 1)
) (
  input  logic                        clk,
  input  logic                        wr,
  input  raace_pkg::entry_t           wdata,
  input  logic [raace_pkg::END_W-1:0] np,
  input  logic [raace_pkg::POS_W-1:0] len,
  input  logic [LVL_W-1:0]            level,
  output raace_pkg::stack_view_t      view,
  output logic [LVL_W-1:0]            new_level
);

  logic [MAX_NESTING-1:0] live;
  logic [MAX_NESTING-1:0] top;
  logic [MAX_NESTING-1:0] wsel;
  logic [MAX_NESTING-1:0] ge;
  raace_pkg::cell_stat_t  stat [MAX_NESTING];
  logic                   pop_any;
  logic [LVL_W-1:0]       low_idx;

  always_comb begin
    for (int i = 0; i < MAX_NESTING; i++) begin
      live[i] = LVL_W'(i) < level;
      top[i]  = live[i] && !(LVL_W'(i + 1) < level);
      wsel[i] = LVL_W'(i) == level;
    end
  end

  for (genvar g = 0; g < MAX_NESTING; g++) begin : g_cell
    logic below;
    logic above;
    if (g == 0) begin : g_first
      assign below = 1'b0;
    end else begin : g_inner_lo
      assign below = ge[g-1];
    end
    if (g == MAX_NESTING - 1) begin : g_last
      assign above = 1'b0;
    end else begin : g_inner_hi
      assign above = ge[g+1];
    end

    raace_cell u_cell (
      .clk      (clk),
      .wr       (wr && wsel[g]),
      .wdata    (wdata),
      .np       (np),
      .len      (len),
      .live     (live[g]),
      .top      (top[g]),
      .below_ge (below),
      .above_ge (above),
      .stat     (stat[g])
    );

    assign ge[g] = stat[g].ge;
  end

  // At most one cell is the top, one the new top and one the lowest closing.
  always_comb begin
    view    = '0;
    pop_any = 1'b0;
    low_idx = '0;
    for (int i = 0; i < MAX_NESTING; i++) begin
      view.top_ge    |= stat[i].top && stat[i].ge;
      view.top_movie |= stat[i].top && stat[i].movie;
      view.top_diff  |= stat[i].top ? stat[i].diff : '0;
      view.nt_live   |= stat[i].newtop;
      view.nt_diff   |= stat[i].newtop ? stat[i].diff : '0;
      view.pop_pad   |= stat[i].lowest && stat[i].pad;
      view.over      |= stat[i].over;
      pop_any        |= stat[i].lowest;
      low_idx        |= stat[i].lowest ? LVL_W'(i) : '0;
    end
    new_level = pop_any ? low_idx : level;
  end

endmodule

`default_nettype wire

>>> rtl/riff_avi_audio_chunk_extractor.sv
// Top level of the AVI audio chunk extractor: byte parser, container stack, result register.
`default_nettype none

// The block takes an AVI file one byte per transfer on the src channel, with
// final_byte set on the last byte, and sustains one byte per clock cycle while no
// result is stalled: bytes may then follow each other in consecutive cycles with
// no gaps. A result transfer on the res channel is produced for every audio payload
// byte (the payload of a chunk whose id ends in "wb" inside a "movi" or "rec "
// list) and for the final byte; it appears in the output register in the cycle
// after the byte that causes it, and the block keeps accepting bytes while that
// result is drained in the same cycle. The rate is set by the container stack, a row
// of MAX_NESTING cells that each compare their end offset with the next byte
// position in parallel, followed by an OR selection of the top entry. The
// final result carries the outcome: 0 ok, 1 bad header, 2 a chunk overruns its
// container or the file, 3 nesting deeper than MAX_NESTING, 4 an audio total
// that is empty or not a multiple of four bytes. When the outcome is not 0,
// the audio bytes already delivered for that file should be discarded. After
// the final byte the block is ready for a new file at once. There is no
// clearing pass after reset; stack entries are written before they are read.
module riff_avi_audio_chunk_extractor #(
  parameter int MAX_NESTING = raace_pkg::MAX_NESTING_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  raace_pkg::src_item_t src_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output raace_pkg::res_item_t res_data
);

  localparam int LVL_W = $clog2(MAX_NESTING + 1);
  localparam int CW    = raace_pkg::CNT_W;
  localparam int EW    = raace_pkg::END_W;
  localparam int PW    = raace_pkg::POS_W;

  // Parser state.
  logic [PW-1:0]     pos;
  logic [PW-1:0]     pos_next;
  raace_pkg::phase_t ph;
  raace_pkg::phase_t ph_next;
  raace_pkg::phase_t ph_eff;
  logic [63:0]       hdr;
  logic [63:0]       hdr_next;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_next;
  logic              pad_pending;
  logic              pad_pending_next;
  logic [LVL_W-1:0]  level;
  logic [LVL_W-1:0]  level_next;
  logic [1:0]        acnt;
  logic [1:0]        acnt_next;
  logic              aseen;
  logic              aseen_next;
  logic [2:0]        err;
  logic [2:0]        err_next;

  // Stack interface.
  logic [EW-1:0]          np;
  logic                   push;
  logic                   keep_push;
  raace_pkg::entry_t      wdata;
  raace_pkg::stack_view_t view;
  logic [LVL_W-1:0]       new_level;

  // Outcome of walking out of finished containers at the next position.
  raace_pkg::phase_t bnd_ph;
  logic [CW-1:0]     bnd_cnt;
  logic              bnd_clr_pad;

  // Result side.
  logic                 take;
  logic                 emit;
  logic                 fin;
  logic                 over;
  logic                 has_res;
  logic [2:0]           outcome;
  raace_pkg::res_item_t res_next;

  // Byte offsets in chunk headers are little endian.
  function automatic logic [31:0] swap_bytes(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // The first error found is the one that is kept.
  function automatic logic [2:0] first_err(input logic [2:0] cur, input logic [2:0] code);
    return (cur == raace_pkg::OUT_OK) ? code : cur;
  endfunction

  // A new byte can enter whenever the output register is empty or draining.
  assign src_stall = res_valid && res_stall;
  assign take      = src_valid && !src_stall;
  assign fin       = src_data.final_byte;
  assign np        = {1'b0, pos} + EW'(1);

  raace_stack #(
    .MAX_NESTING (MAX_NESTING)
  ) u_stack (
    .clk       (clk),
    .wr        (take && push),
    .wdata     (wdata),
    .np        (np),
    .len       (pos_next),
    .level     (level),
    .view      (view),
    .new_level (new_level)
  );

  // After the containers ending here are closed, a closed container of odd
  // size leaves a pad byte, a tail too short for a chunk header is skipped to
  // the enclosing end, and otherwise a new chunk header starts.
  always_comb begin
    bnd_clr_pad = 1'b0;
    if (view.pop_pad) begin
      bnd_ph  = raace_pkg::PH_PAD;
      bnd_cnt = '0;
    end else if (view.nt_live && (view.nt_diff < EW'(8))) begin
      bnd_ph      = raace_pkg::PH_DATA;
      bnd_cnt     = CW'(view.nt_diff[2:0]);
      bnd_clr_pad = 1'b1;
    end else begin
      bnd_ph  = raace_pkg::PH_CHDR;
      bnd_cnt = '0;
    end
  end

  // Next-state logic of the parser.
  always_comb begin
    logic [31:0]   csize;
    logic [31:0]   cid;
    logic [31:0]   lsize;
    logic [31:0]   lkind;
    logic [CW-1:0] cnt_dec;
    logic          aud;
    logic          movie;

    hdr_next         = {hdr[55:0], src_data.file_byte};
    ph_next          = ph;
    cnt_next         = cnt;
    pad_pending_next = pad_pending;
    level_next       = level;
    err_next         = err;
    acnt_next        = acnt;
    aseen_next       = aseen;
    push             = 1'b0;
    keep_push        = 1'b0;
    ph_eff           = ph;

    cid     = hdr_next[63:32];
    csize   = swap_bytes(hdr_next[31:0]);
    lkind   = hdr_next[31:0];
    lsize   = swap_bytes(hdr_next[63:32]);
    cnt_dec = (cnt != '0) ? cnt - CW'(1) : '0;
    aud     = (level != '0) && view.top_movie &&
              (cid[15:8] == raace_pkg::CHAR_W) && (cid[7:0] == raace_pkg::CHAR_B);
    movie   = (lkind == raace_pkg::TAG_MOVI) || (lkind == raace_pkg::TAG_REC) ||
              ((level != '0) && view.top_movie);

    wdata.end_pos = np + {3'b000, lsize} - EW'(4);
    wdata.movie   = movie;
    wdata.pad     = lsize[0];

    // A byte arriving at the saturated position means the file is too long.
    if ((ph != raace_pkg::PH_HALT) && (pos == raace_pkg::POS_MAX)) begin
      err_next = first_err(err, raace_pkg::OUT_OVERRUN);
      ph_eff   = raace_pkg::PH_HALT;
      ph_next  = raace_pkg::PH_HALT;
    end

    case (ph_eff)
      raace_pkg::PH_FILEHDR: begin
        if ((pos == PW'(3)) && (hdr_next[31:0] != raace_pkg::TAG_RIFF)) begin
          err_next = first_err(err_next, raace_pkg::OUT_BAD_HEADER);
          ph_next  = raace_pkg::PH_HALT;
        end else if (pos == PW'(11)) begin
          if (hdr_next[31:0] != raace_pkg::TAG_AVI) begin
            err_next = first_err(err_next, raace_pkg::OUT_BAD_HEADER);
            ph_next  = raace_pkg::PH_HALT;
          end else begin
            ph_next    = bnd_ph;
            cnt_next   = bnd_cnt;
            level_next = new_level;
            if (bnd_clr_pad) begin
              pad_pending_next = 1'b0;
            end
          end
        end
      end
      raace_pkg::PH_CHDR: begin
        cnt_next = cnt + CW'(1);
        if (cnt >= CW'(7)) begin
          if ((level != '0) && ({3'b000, csize} > view.top_diff)) begin
            err_next = first_err(err_next, raace_pkg::OUT_OVERRUN);
            ph_next  = raace_pkg::PH_HALT;
          end else if (((cid == raace_pkg::TAG_LIST) || (cid == raace_pkg::TAG_RIFF)) &&
                       (csize >= 32'd4)) begin
            ph_next  = raace_pkg::PH_LISTTYPE;
            cnt_next = '0;
          end else begin
            ph_next          = aud ? raace_pkg::PH_AUDIO : raace_pkg::PH_DATA;
            cnt_next         = csize;
            pad_pending_next = csize[0];
            if (csize == 32'd0) begin
              ph_next    = bnd_ph;
              cnt_next   = bnd_cnt;
              level_next = new_level;
            end
          end
        end
      end
      raace_pkg::PH_LISTTYPE: begin
        cnt_next = cnt + CW'(1);
        if (cnt >= CW'(3)) begin
          if (level >= LVL_W'(MAX_NESTING)) begin
            err_next = first_err(err_next, raace_pkg::OUT_TOO_DEEP);
            ph_next  = raace_pkg::PH_HALT;
          end else begin
            push = 1'b1;
            if (lsize <= 32'd4) begin
              // An empty list closes at once; only the enclosing ends count.
              ph_next    = bnd_ph;
              cnt_next   = bnd_cnt;
              level_next = new_level;
              if (bnd_clr_pad) begin
                pad_pending_next = 1'b0;
              end
            end else begin
              keep_push  = 1'b1;
              level_next = level + LVL_W'(1);
              if ((lsize - 32'd4) < 32'd8) begin
                ph_next          = raace_pkg::PH_DATA;
                cnt_next         = lsize - 32'd4;
                pad_pending_next = 1'b0;
              end else begin
                ph_next  = raace_pkg::PH_CHDR;
                cnt_next = '0;
              end
            end
          end
        end
      end
      raace_pkg::PH_DATA, raace_pkg::PH_AUDIO: begin
        if (ph_eff == raace_pkg::PH_AUDIO) begin
          aseen_next = 1'b1;
          acnt_next  = acnt + 2'd1;
        end
        cnt_next = cnt_dec;
        if (cnt_dec == '0) begin
          if (pad_pending && ((level == '0) || !view.top_ge)) begin
            pad_pending_next = 1'b0;
            ph_next          = raace_pkg::PH_PAD;
          end else begin
            // A pad byte is dropped when the chunk ends with its container.
            pad_pending_next = 1'b0;
            ph_next          = bnd_ph;
            cnt_next         = bnd_cnt;
            level_next       = new_level;
          end
        end
      end
      raace_pkg::PH_PAD: begin
        ph_next    = bnd_ph;
        cnt_next   = bnd_cnt;
        level_next = new_level;
        if (bnd_clr_pad) begin
          pad_pending_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    pos_next = (pos != raace_pkg::POS_MAX) ? pos + PW'(1) : pos;
  end

  // Result logic: one result per audio byte and one for the final byte.
  always_comb begin
    emit    = (ph_eff == raace_pkg::PH_AUDIO);
    has_res = emit || fin;
    over    = view.over || (keep_push && (wdata.end_pos > {1'b0, pos_next}));

    if ((ph_next == raace_pkg::PH_FILEHDR) || (err_next == raace_pkg::OUT_BAD_HEADER)) begin
      outcome = raace_pkg::OUT_BAD_HEADER;
    end else if (over) begin
      outcome = raace_pkg::OUT_OVERRUN;
    end else if (err_next != raace_pkg::OUT_OK) begin
      outcome = err_next;
    end else if ((ph_next == raace_pkg::PH_DATA) || (ph_next == raace_pkg::PH_AUDIO) ||
                 (ph_next == raace_pkg::PH_LISTTYPE)) begin
      outcome = raace_pkg::OUT_OVERRUN;
    end else if (!aseen_next || (acnt_next != 2'd0)) begin
      outcome = raace_pkg::OUT_NO_AUDIO;
    end else begin
      outcome = raace_pkg::OUT_OK;
    end

    res_next.audio_byte  = emit ? src_data.file_byte : 8'd0;
    res_next.audio_valid = emit;
    res_next.finished    = fin;
    res_next.outcome     = fin ? outcome : raace_pkg::OUT_OK;
  end

  // Parser registers; the final byte returns the block to its reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      ph          <= raace_pkg::PH_FILEHDR;
      cnt         <= '0;
      pad_pending <= 1'b0;
      level       <= '0;
      acnt        <= 2'd0;
      aseen       <= 1'b0;
      err         <= raace_pkg::OUT_OK;
    end else if (take) begin
      if (fin) begin
        pos         <= '0;
        ph          <= raace_pkg::PH_FILEHDR;
        cnt         <= '0;
        pad_pending <= 1'b0;
        level       <= '0;
        acnt        <= 2'd0;
        aseen       <= 1'b0;
        err         <= raace_pkg::OUT_OK;
      end else begin
        pos         <= pos_next;
        ph          <= ph_next;
        cnt         <= cnt_next;
        pad_pending <= pad_pending_next;
        level       <= level_next;
        acnt        <= acnt_next;
        aseen       <= aseen_next;
        err         <= err_next;
      end
    end
  end

  // The header shift register is pure payload.
  always_ff @(posedge clk) begin
    if (take) begin
      hdr <= hdr_next;
    end
  end

  // Output register: loaded on every transfer in, cleared once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= has_res;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_data <= res_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/raace_checker.sv
// Port-level checker of the AVI audio chunk extractor and its bind statement.
`default_nettype none

module raace_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 src_valid,
  input logic                 src_stall,
  input raace_pkg::src_item_t src_data,
  input logic                 res_valid,
  input logic                 res_stall,
  input raace_pkg::res_item_t res_data
);

  // A result that does not close the file is an audio byte with no outcome.
  a_mid_is_audio: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.finished) |->
      (res_data.audio_valid && (res_data.outcome == raace_pkg::OUT_OK)))
    else $error("result without finished flag is not a clean audio byte");

  // A result with no audio byte must be the final one and carry a zero byte.
  a_empty_is_final: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.audio_valid) |->
      (res_data.finished && (res_data.audio_byte == 8'd0)))
    else $error("result without audio byte is not a final result");

  // The final flag of a transfer in shows up on the very next result slot.
  a_final_follows: assert property (@(posedge clk) disable iff (rst)
    (src_valid && !src_stall) |=>
      ((res_valid && res_data.finished) == $past(src_data.final_byte)))
    else $error("final result does not follow the final byte");

  // A stalled result stays put.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
    else $error("stalled result changed");

endmodule

bind riff_avi_audio_chunk_extractor raace_checker u_raace_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_data  (src_data),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

`default_nettype wire
